/* hdl/integer_to_radix_ascii_defines.svh */
// Assertion macros used by the checker of the radix converter
`ifndef INTEGER_TO_RADIX_ASCII_DEFINES_SVH
`define INTEGER_TO_RADIX_ASCII_DEFINES_SVH

// Check a property on every rising edge outside reset
`define ITRA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on every rising edge, reset included
`define ITRA_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* hdl/itra_pkg.sv */
// Types, constants and helper functions of the radix ASCII converter
package itra_pkg;

  localparam int RADIX_W    = 6;
  localparam int CHAR_W     = 8;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 32;
  localparam int DIV_STEPS  = 8;   // quotient bits resolved per cycle

  localparam logic [RADIX_W-1:0]    RADIX_MIN   = 6'd2;
  localparam logic [RADIX_W-1:0]    RADIX_MAX   = 6'd36;
  localparam logic [RADIX_W-1:0]    RADIX_DEC   = 6'd10;
  localparam logic [RADIX_W-1:0]    RADIX_RESET = 6'd10;
  localparam logic [CHAR_W-1:0]     CHAR_ZERO   = 8'd48;
  localparam logic [CHAR_W-1:0]     CHAR_ALPHA  = 8'd65;
  localparam logic [CHAR_W-1:0]     CHAR_MINUS  = 8'd45;
  localparam logic [CFG_ADDR_W-1:0] ADDR_RADIX  = 2'd0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SIGN,
    ST_READ,
    ST_LOAD
  } itra_state_t;

  typedef struct packed {
    logic load;       // capture a new value
    logic div_step;   // run one division cycle
    logic sign_load;  // put the minus sign in the output register
    logic rd_issue;   // read the next stored digit
    logic char_load;  // put the read digit in the output register
  } itra_cmd_t;

  typedef struct packed {
    logic step_last;  // this division cycle finishes a digit
    logic q_zero;     // the quotient after this cycle is zero
    logic need_sign;  // value is negative and radix is ten
    logic cnt_zero;   // the digit just read is the least significant one
    logic out_free;   // the output register can take a character
  } itra_sts_t;

  // Clamp the radix register to the supported range
  function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
    logic [RADIX_W-1:0] res;
    res = r;
    if (r < RADIX_MIN) res = RADIX_MIN;
    if (r > RADIX_MAX) res = RADIX_MAX;
    return res;
  endfunction

  // Map a digit value to its ASCII character
  function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
    logic [CHAR_W-1:0] dw;
    dw = CHAR_W'(d);
    if (d >= RADIX_DEC) return CHAR_ALPHA + dw - CHAR_W'(RADIX_DEC);
    return CHAR_ZERO + dw;
  endfunction

endpackage

/* hdl/itra_if.sv */
// Valid/ready channel interfaces for input values and output characters

interface itra_in_if #(parameter int VALUE_WIDTH = 32);
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface itra_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last;

  modport source (output valid, output char_code, output last, input ready);
  modport sink   (input valid, input char_code, input last, output ready);
endinterface

/* hdl/itra_ram.sv */
// Generic single-write, single-read RAM with registered read data
module itra_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port, holds between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

/* hdl/itra_regs.sv */
// APB register block holding the radix register
module itra_regs
  import itra_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [CFG_ADDR_W-1:0]   paddr,
  input  logic [CFG_DATA_W-1:0]   pwdata,
  output logic [CFG_DATA_W-1:0]   prdata,
  output logic                    pready,
  output logic [RADIX_W-1:0]      radix
);

  logic [RADIX_W-1:0] radix_r;
  logic               wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready && (paddr == ADDR_RADIX);

  // Update the radix on the access beat of a write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= RADIX_RESET;
    end else if (wr_en) begin
      radix_r <= pwdata[RADIX_W-1:0];
    end
  end

  // Read back the register, zero elsewhere
  always_comb begin
    prdata = '0;
    if (paddr == ADDR_RADIX) begin
      prdata = CFG_DATA_W'(radix_r);
    end
  end

  assign radix = radix_r;

endmodule

/* hdl/itra_ctrl.sv */
// Controller state machine sequencing division, digit storage and output
module itra_ctrl
  import itra_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  itra_sts_t sts,
  output itra_cmd_t cmd
);

  itra_state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.step_last && sts.q_zero) begin
          state_nxt = ST_SIGN;
        end
      end
      ST_SIGN: begin
        if (!sts.need_sign) begin
          state_nxt = ST_READ;
        end else if (sts.out_free) begin
          cmd.sign_load = 1'b1;
          state_nxt     = ST_READ;
        end
      end
      ST_READ: begin
        cmd.rd_issue = 1'b1;
        state_nxt    = ST_LOAD;
      end
      ST_LOAD: begin
        // Hand over the read digit and fetch the next one in the same cycle
        if (sts.out_free) begin
          cmd.char_load = 1'b1;
          if (sts.cnt_zero) begin
            state_nxt = ST_IDLE;
          end else begin
            cmd.rd_issue = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

/* hdl/itra_dp.sv */
// Datapath: magnitude, digit divider, digit store and output register
module itra_dp
  import itra_pkg::*;
#(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic signed [VALUE_WIDTH-1:0] in_value,
  input  logic [RADIX_W-1:0]            radix_cfg,
  input  itra_cmd_t                     cmd,
  output itra_sts_t                     sts,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [CHAR_W-1:0]             out_char_code,
  output logic                          out_last
);

  localparam int MAG_W = ((VALUE_WIDTH + DIV_STEPS - 1) / DIV_STEPS) * DIV_STEPS;
  localparam int NSTEP = MAG_W / DIV_STEPS;
  localparam int SW    = (NSTEP > 1) ? $clog2(NSTEP) : 1;
  localparam int CW    = $clog2(VALUE_WIDTH + 1);
  localparam int AW    = $clog2(VALUE_WIDTH);

  logic [MAG_W-1:0]       quo_r, quo_nxt;
  logic [RADIX_W-1:0]     rem_r, rem_nxt;
  logic [RADIX_W:0]       part;
  logic [RADIX_W-1:0]     radix_r, radix_eff;
  logic                   need_sign_r;
  logic [SW-1:0]          step_r;
  logic [CW-1:0]          cnt_r, cnt_dec;
  logic                   out_valid_r;
  logic [CHAR_W-1:0]      out_char_r;
  logic                   out_last_r;
  logic [VALUE_WIDTH-1:0] mag;
  logic                   step_last;
  logic                   digit_we;
  logic [RADIX_W-1:0]     digit_rd;

  assign radix_eff = clamp_radix(radix_cfg);
  assign mag       = in_value[VALUE_WIDTH-1] ? VALUE_WIDTH'(-in_value) : in_value;
  assign step_last = (step_r == SW'(NSTEP - 1));
  assign cnt_dec   = cnt_r - CW'(1);
  assign digit_we  = cmd.div_step && step_last;

  // Restoring division by the radix, several quotient bits per cycle
  always_comb begin
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    part    = '0;
    for (int i = 0; i < DIV_STEPS; i++) begin
      part    = {rem_nxt, quo_nxt[MAG_W-1]};
      quo_nxt = {quo_nxt[MAG_W-2:0], 1'b0};
      if (part >= {1'b0, radix_r}) begin
        part       = part - {1'b0, radix_r};
        quo_nxt[0] = 1'b1;
      end
      rem_nxt = part[RADIX_W-1:0];
    end
  end

  // Capture the magnitude, then run the division passes
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      quo_r       <= MAG_W'(mag);
      rem_r       <= '0;
      radix_r     <= radix_eff;
      need_sign_r <= in_value[VALUE_WIDTH-1] && (radix_eff == RADIX_DEC);
    end else if (cmd.div_step) begin
      quo_r <= quo_nxt;
      rem_r <= step_last ? '0 : rem_nxt;
    end
  end

  // Division cycle and digit count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (cmd.load) begin
        step_r <= '0;
        cnt_r  <= '0;
      end else begin
        if (cmd.div_step) begin
          step_r <= step_last ? '0 : step_r + SW'(1);
        end
        if (digit_we) begin
          cnt_r <= cnt_r + CW'(1);
        end else if (cmd.rd_issue) begin
          cnt_r <= cnt_dec;
        end
      end
    end
  end

  // Digits land least significant first and leave in reverse
  itra_ram #(
    .WIDTH (RADIX_W),
    .DEPTH (VALUE_WIDTH)
  ) u_digits (
    .clk     (clk),
    .we      (digit_we),
    .waddr   (cnt_r[AW-1:0]),
    .wdata   (rem_nxt),
    .re      (cmd.rd_issue),
    .raddr   (cnt_dec[AW-1:0]),
    .rdata_r (digit_rd)
  );

  // Output register: load a character or drop it once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.sign_load || cmd.char_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sign_load) begin
      out_char_r <= CHAR_MINUS;
      out_last_r <= 1'b0;
    end else if (cmd.char_load) begin
      out_char_r <= digit_char(digit_rd);
      out_last_r <= (cnt_r == '0);
    end
  end

  assign out_valid     = out_valid_r;
  assign out_char_code = out_char_r;
  assign out_last      = out_last_r;

  assign sts.step_last = step_last;
  assign sts.q_zero    = (quo_nxt == '0);
  assign sts.need_sign = need_sign_r;
  assign sts.cnt_zero  = (cnt_r == '0);
  assign sts.out_free  = !out_valid_r || out_ready;

endmodule

/* hdl/integer_to_radix_ascii.sv */
// Signed integer to ASCII digit string converter in a configurable radix
//
// Input channel in_if carries one signed value per beat; output channel out_if
// carries one ASCII character per beat, most significant digit first, with
// last set on the final character. Radix 10 negatives get a leading '-'.
// The radix register (APB, address 0) keeps the raw code; 2..36 is used as
// is and other codes clamp to the nearest end. Write it only while no value
// is in flight. One value is worked at a time: in_if.ready is high only when
// idle. Each digit is worked out by the shared restoring divider (8 quotient
// bits per cycle) and put in the digit store. Then the optional sign is sent,
// the first digit-store read is issued, and the stored digits are read out
// one by one as characters. A value of zero gives the single character '0'.
// When out_if.ready is low, the held character stays and the digit readout
// pauses; nothing is lost. Reset (rst_n low, synchronous) drops any value
// in flight, empties the output register and sets the radix to 10.
module integer_to_radix_ascii
  import itra_pkg::*;
#(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  itra_in_if.sink               in_if,
  itra_out_if.source            out_if,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [RADIX_W-1:0] radix;
  itra_cmd_t          cmd;
  itra_sts_t          sts;

  itra_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .radix   (radix)
  );

  itra_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_if.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  itra_dp #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_value      (in_if.value),
    .radix_cfg     (radix),
    .cmd           (cmd),
    .sts           (sts),
    .out_ready     (out_if.ready),
    .out_valid     (out_if.valid),
    .out_char_code (out_if.char_code),
    .out_last      (out_if.last)
  );

endmodule

/* hdl/itra_chk.sv */
// Port-level checker for the radix converter and its bind
`include "integer_to_radix_ascii_defines.svh"

module itra_chk
  import itra_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_char,
  input logic       out_last
);

  logic in_beat;
  logic is_digit;
  logic is_letter;
  logic is_minus;
  logic char_legal;

  // Input beat taken this cycle
  assign in_beat    = in_valid && in_ready;

  // Classify the character on the output
  assign is_digit   = (out_char >= CHAR_ZERO) && (out_char < CHAR_ZERO + CHAR_W'(RADIX_DEC));
  assign is_letter  = (out_char >= CHAR_ALPHA) &&
                      (out_char < CHAR_ALPHA + CHAR_W'(RADIX_MAX - RADIX_DEC));
  assign is_minus   = (out_char == CHAR_MINUS);
  assign char_legal = is_digit || is_letter || is_minus;

  // A stalled beat keeps its character and flag
  property p_out_hold;
    out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(out_last);
  endproperty

  `ITRA_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid, "output valid after reset")
  `ITRA_ASSERT(a_out_hold, p_out_hold, "stalled output beat changed")
  `ITRA_ASSERT(a_busy_after_accept, in_beat |=> !in_ready, "second value taken while converting")
  `ITRA_ASSERT(a_legal_char, out_valid |-> char_legal, "illegal character")
  `ITRA_ASSERT(a_sign_not_last, out_valid && is_minus |-> !out_last, "minus sign flagged last")

endmodule

bind integer_to_radix_ascii itra_chk u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_if.valid),
  .in_ready  (in_if.ready),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .out_char  (out_if.char_code),
  .out_last  (out_if.last)
);

/* verif/integer_to_radix_ascii_test.sv */
// Self-checking bench for the radix ASCII converter: directed table, then random phases
module integer_to_radix_ascii_test
  import itra_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int VALUE_W       = 32;
  localparam int NUM_DIRECTED  = 25;
  localparam int NUM_PHASES    = 6;
  localparam int PHASE_VALUES  = 21;
  localparam int SETTLE_CYCLES = 64;
  localparam int CYCLE_LIMIT   = 400000;

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              last;
  } char_beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  itra_in_if #(.VALUE_WIDTH(VALUE_W)) in_ch ();
  itra_out_if out_ch ();

  // Radix code as last written to the block, raw six bits
  logic [RADIX_W-1:0] radix_code = RADIX_RESET;

  char_beat_t pending_chars[$];
  int idle_pct = 0;
  int stall_pct = 0;
  int error_count = 0;
  int values_sent = 0;
  int chars_checked = 0;
  int radix_writes = 0;
  int cycle_count = 0;

  // Directed table; an empty text means the predictor supplies the string
  logic [RADIX_W-1:0]       dir_radix [NUM_DIRECTED] = '{
    6'd10, 6'd10, 6'd10, 6'd10, 6'd10, 6'd10, 6'd10,
    6'd2, 6'd2, 6'd2, 6'd2,
    6'd36, 6'd36, 6'd36,
    6'd16, 6'd16,
    6'd0, 6'd1, 6'd37, 6'd63,
    6'd11, 6'd8, 6'd10, 6'd3, 6'd10
  };
  logic signed [VALUE_W-1:0] dir_value [NUM_DIRECTED] = '{
    32'sd0, 32'sd1, -32'sd1, 32'h7FFF_FFFF, 32'h8000_0000, 32'sd9, -32'sd987654321,
    32'h8000_0000, -32'sd1, 32'sd0, 32'h7FFF_FFFF,
    32'sd35, 32'h7FFF_FFFF, -32'sd36,
    32'sd255, 32'hDEAD_BEEF,
    32'sd5, -32'sd6, 32'sd35, 32'sd71,
    -32'sd10, -32'sd8, -32'sd10, 32'h8000_0000, 32'sd100
  };
  string dir_text [NUM_DIRECTED] = '{
    "0", "1", "-1", "2147483647", "-2147483648", "9", "",
    "", "1", "0", "",
    "Z", "", "10",
    "FF", "",
    "101", "110", "Z", "1Z",
    "A", "10", "-10", "", "100"
  };

  integer_to_radix_ascii #(.VALUE_WIDTH(VALUE_W)) uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (in_ch),
    .out_if  (out_ch),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready)
  );

  always #5 clk = ~clk;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.value = '0;
    out_ch.ready = 1'b0;
  end

  // Spell a value in the given radix code, most significant character first
  function automatic void spell_value(input logic [VALUE_W-1:0] v,
                                      input logic [RADIX_W-1:0] code);
    logic [RADIX_W-1:0] base;
    logic [VALUE_W-1:0] mag;
    logic [VALUE_W-1:0] d;
    logic [CHAR_W-1:0]  digits[$];
    char_beat_t         beat;
    base = code;
    if (base < RADIX_MIN) base = RADIX_MIN;
    if (base > RADIX_MAX) base = RADIX_MAX;
    // the two's complement of the most negative value reads as 2^31 unsigned
    mag = v[VALUE_W-1] ? (~v + 1'b1) : v;
    if (mag == '0) digits.push_front(CHAR_ZERO);
    while (mag != '0) begin
      d = mag % VALUE_W'(base);
      if (d >= VALUE_W'(RADIX_DEC))
        digits.push_front(CHAR_ALPHA + CHAR_W'(d) - CHAR_W'(RADIX_DEC));
      else
        digits.push_front(CHAR_ZERO + CHAR_W'(d));
      mag = mag / VALUE_W'(base);
    end
    if (v[VALUE_W-1] && base == RADIX_DEC) begin
      beat = '{char_code: CHAR_MINUS, last: 1'b0};
      pending_chars.push_back(beat);
    end
    foreach (digits[i]) begin
      beat = '{char_code: digits[i], last: (i == digits.size() - 1)};
      pending_chars.push_back(beat);
    end
  endfunction

  // Queue a string read straight off the table
  function automatic void queue_text(input string s);
    char_beat_t beat;
    for (int i = 0; i < s.len(); i++) begin
      beat = '{char_code: CHAR_W'(s[i]), last: (i == s.len() - 1)};
      pending_chars.push_back(beat);
    end
  endfunction

  // Mix of full-range, small, shifted and edge values
  function automatic logic [VALUE_W-1:0] pick_value();
    logic [VALUE_W-1:0] r;
    case ($urandom_range(3))
      0: r = $urandom;
      1: r = VALUE_W'(int'($urandom_range(200)) - 100);
      2: begin
        r = $urandom >> $urandom_range(VALUE_W - 1);
        if ($urandom_range(1) == 1) r = ~r + 1'b1;
      end
      default: begin
        case ($urandom_range(3))
          0: r = 32'h8000_0000;
          1: r = 32'h7FFF_FFFF;
          2: r = 32'h8000_0001;
          default: r = 32'hFFFF_FFFF;
        endcase
      end
    endcase
    return r;
  endfunction

  // Present one value; called and left at a falling edge
  task automatic send_value(input logic [VALUE_W-1:0] v, input string text);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.value <= v;
    do @(posedge clk); while (!in_ch.ready);
    if (text.len() == 0) spell_value(v, radix_code);
    else queue_text(text);
    values_sent++;
    @(negedge clk);
  endtask

  // Drop valid and hold until every character is out and the block is idle
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (pending_chars.size() != 0 || !in_ch.ready) @(negedge clk);
  endtask

  // Drain, then write the radix register through a setup and an access cycle
  task automatic write_radix(input logic [RADIX_W-1:0] code);
    logic [CFG_DATA_W-1:0] data;
    drain();
    data = $urandom;
    data[RADIX_W-1:0] = code;
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= ADDR_RADIX;
    cfg_pwdata <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    radix_code = code;
    radix_writes++;
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // Randomize receiver stalls
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Check each character beat against the oldest expectation
  always @(posedge clk) begin : char_check
    char_beat_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_chars.size() == 0) begin
        $error("unexpected beat: char_code %0d last %0b", out_ch.char_code, out_ch.last);
        error_count++;
      end else begin
        want = pending_chars.pop_front();
        chars_checked++;
        if (out_ch.char_code !== want.char_code) begin
          $error("char_code: expected %0d, got %0d", want.char_code, out_ch.char_code);
          error_count++;
        end
        if (out_ch.last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, out_ch.last);
          error_count++;
        end
      end
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[integer_to_radix_ascii] ERROR");
      $finish;
    end
  end

  initial begin : main
    logic [RADIX_W-1:0] code;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Walk the directed table without idling
    for (int i = 0; i < NUM_DIRECTED; i++) begin
      if (dir_radix[i] != radix_code || (i == NUM_DIRECTED - 3)) write_radix(dir_radix[i]);
      send_value(dir_value[i], dir_text[i]);
    end

    // Random phases, each writing a radix and using one of four idling mixes
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: code = RADIX_DEC;
        1: code = RADIX_MIN;
        2: code = RADIX_MAX;
        3: code = RADIX_W'($urandom_range(36, 2));
        4: code = RADIX_W'($urandom_range(63));
        default: code = 6'd16;
      endcase
      write_radix(code);
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 54; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 54; end
        default: begin idle_pct = 33; stall_pct = 33; end
      endcase
      for (int n = 0; n < PHASE_VALUES; n++) send_value(pick_value(), "");
    end

    // Let the tail drain, then watch for stray beats
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Checked %0d characters from %0d values over %0d radix writes,",
             chars_checked, values_sent, radix_writes);
    $display("including clamped radix codes and sender/receiver idling mixes.");
    if (error_count == 0) begin
      $display("[integer_to_radix_ascii] OK");
    end else begin
      $display("[integer_to_radix_ascii] ERROR");
    end
    $finish;
  end

endmodule
